>>> rtl/core/pwm_prescaler_reload_search_assert.svh
// assertion macros included by the top rtl file of the prescaler search
`ifndef PWM_PRESCALER_RELOAD_SEARCH_ASSERT_SVH
`define PWM_PRESCALER_RELOAD_SEARCH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prescaler search assertion failed");

// next-cycle implication, checked outside reset
`define PRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prescaler search assertion failed");

`endif

>>> rtl/core/pwmprs_pkg.sv
`timescale 1ns / 1ps
package pwmprs_pkg;

    localparam int unsigned DIV_W             = 32;
    localparam int unsigned PRESCALE_TRIES_DEF = 16;
    localparam int unsigned PADDR_W           = 3;

    localparam logic [31:0] TIMER_CLOCK_RST = 32'd170000000;
    localparam logic [31:0] MIN_KEEP_PER    = 32'd200;
    localparam logic [31:0] MAX_KEEP_PER    = 32'd60000;
    localparam logic [31:0] MAX_PERIODS     = 32'h0001_0000;
    localparam logic [31:0] MAX_DIVIDER     = 32'h0000_FFFF;
    localparam logic [16:0] DUTY_ONE        = 17'h1_0000;

    // register index within the configuration space
    localparam logic REG_TIMER_CLOCK = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PER_GO,
        S_PER_WAIT,
        S_REAL_GO,
        S_REAL_WAIT,
        S_FBQ_GO,
        S_FBQ_WAIT,
        S_FBP_GO,
        S_FBP_WAIT,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] tone_freq_hz;
        logic [16:0] duty_q16;
    } t_in_item;

    typedef struct packed {
        logic        setting_ok;
        logic [15:0] prescale_value;
        logic [15:0] reload_value;
        logic [15:0] compare_value;
        logic        fallback_used;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/core/pwmprs_div.sv
`timescale 1ns / 1ps
module pwmprs_div
    import pwmprs_pkg::*;
#(
    parameter int unsigned WIDTH = DIV_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_div_stat        o_stat,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // restoring division, one quotient bit a cycle, msb first
    always_comb begin
        trial  = {r_rem, r_quo[WIDTH-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = trial[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

>>> rtl/core/pwm_prescaler_reload_search.sv
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_stall       i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall     o_out_data (t_out_item)
// config    input      psel penable pwrite pready    paddr pwdata prdata
//
// one item at a time; each 32-bit division runs on the shared divider
// a tried prescaler costs one division, or two when its period count is kept
// with zero clock or frequency the search is skipped and the state goes straight to S_OUT;
// at most nine of the sixteen period counts can be kept, so an item needs at most
// 25 divisions; the fallback path takes at most 18 divisions
// o_in_stall is high from acceptance until the result is loaded into the output
// register, which holds while i_out_stall is high
// synchronous active-low reset restores the timer clock to 170 MHz
`timescale 1ns / 1ps
module pwm_prescaler_reload_search
    import pwmprs_pkg::*;
#(
    parameter int unsigned PRESCALE_TRIES = PRESCALE_TRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "pwm_prescaler_reload_search_assert.svh"

    localparam int unsigned IDX_W = (PRESCALE_TRIES > 1) ? $clog2(PRESCALE_TRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PRESCALE_TRIES - 1);

    t_state      r_state, n_state;
    logic [31:0] r_clk_hz;
    logic [31:0] r_freq, n_freq;
    logic [16:0] r_duty, n_duty;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic        r_found, n_found;
    logic        r_ok, n_ok;
    logic        r_fallback, n_fallback;
    logic [31:0] r_min_err, n_min_err;
    logic [16:0] r_best_per, n_best_per;
    logic [15:0] r_best_pre, n_best_pre;
    logic [16:0] r_per, n_per;
    logic [31:0] r_q0, n_q0;
    logic [15:0] r_fb_div, n_fb_div;
    logic [33:0] r_prod, n_prod;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_div_req    div_req;
    t_div_stat   div_stat;
    logic [31:0] div_q;

    logic        wr_en;
    logic        out_free;
    logic [31:0] err;
    logic        better;
    logic [15:0] reload;
    logic [17:0] cmp_full;

    pwmprs_div #(
        .WIDTH(DIV_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .o_stat    (div_stat),
        .o_quotient(div_q)
    );

    // configuration register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMER_CLOCK);
    assign prdata = (paddr[2] == REG_TIMER_CLOCK) ? r_clk_hz : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= TIMER_CLOCK_RST;
        end else if (wr_en) begin
            r_clk_hz <= pwdata;
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign err        = (div_q > r_freq) ? (div_q - r_freq) : (r_freq - div_q);
    assign better     = !r_found || (err < r_min_err);
    assign reload     = 16'(r_best_per - 17'd1);
    assign cmp_full   = r_prod[33:16];

    always_comb begin
        n_state     = r_state;
        n_freq      = r_freq;
        n_duty      = r_duty;
        n_idx       = r_idx;
        n_found     = r_found;
        n_ok        = r_ok;
        n_fallback  = r_fallback;
        n_min_err   = r_min_err;
        n_best_per  = r_best_per;
        n_best_pre  = r_best_pre;
        n_per       = r_per;
        n_q0        = r_q0;
        n_fb_div    = r_fb_div;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_freq     = i_in_data.tone_freq_hz;
                    n_duty     = i_in_data.duty_q16[16] ? DUTY_ONE : i_in_data.duty_q16;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_fallback = 1'b0;
                    if (i_in_data.tone_freq_hz == '0 || r_clk_hz == '0) begin
                        n_ok    = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = S_PER_GO;
                    end
                end
            end
            S_PER_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_clk_hz >> r_idx;
                div_req.divisor  = r_freq;
                n_state          = S_PER_WAIT;
            end
            S_PER_WAIT: begin
                if (div_stat.done) begin
                    if (r_idx == '0) begin
                        n_q0 = div_q;
                    end
                    n_per = div_q[16:0];
                    if (div_q >= MIN_KEEP_PER && div_q <= MAX_KEEP_PER) begin
                        n_state = S_REAL_GO;
                    end else if (r_idx != IDX_LAST) begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_PER_GO;
                    end else begin
                        n_state = r_found ? S_CMP : S_FBQ_GO;
                    end
                end
            end
            S_REAL_GO: begin
                // achieved frequency for this prescaler
                div_req.start    = 1'b1;
                div_req.dividend = r_clk_hz >> r_idx;
                div_req.divisor  = {15'd0, r_per};
                n_state          = S_REAL_WAIT;
            end
            S_REAL_WAIT: begin
                if (div_stat.done) begin
                    if (better) begin
                        n_found    = 1'b1;
                        n_min_err  = err;
                        n_best_per = r_per;
                        n_best_pre = (16'd1 << r_idx) - 16'd1;
                    end
                    if (better && err == '0) begin
                        n_state = S_CMP;
                    end else if (r_idx != IDX_LAST) begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_PER_GO;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_FBQ_GO: begin
                // clock / (freq * 60000) taken as (clock / freq) / 60000
                div_req.start    = 1'b1;
                div_req.dividend = r_q0;
                div_req.divisor  = MAX_KEEP_PER;
                n_state          = S_FBQ_WAIT;
            end
            S_FBQ_WAIT: begin
                if (div_stat.done) begin
                    if (div_q >= MAX_DIVIDER) begin
                        n_ok    = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_fb_div = div_q[15:0] + 16'd1;
                        n_state  = S_FBP_GO;
                    end
                end
            end
            S_FBP_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_q0;
                div_req.divisor  = {16'd0, r_fb_div};
                n_state          = S_FBP_WAIT;
            end
            S_FBP_WAIT: begin
                if (div_stat.done) begin
                    if (div_q == '0 || div_q > MAX_PERIODS) begin
                        n_ok    = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_best_per = div_q[16:0];
                        n_best_pre = r_fb_div - 16'd1;
                        n_fallback = 1'b1;
                        n_state    = S_CMP;
                    end
                end
            end
            S_CMP: begin
                n_prod  = {17'd0, r_duty} * {17'd0, r_best_per};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_ok) begin
                        n_out.setting_ok     = 1'b1;
                        n_out.prescale_value = r_best_pre;
                        n_out.reload_value   = reload;
                        n_out.compare_value  = (cmp_full > {2'b00, reload}) ? reload
                                                                            : cmp_full[15:0];
                        n_out.fallback_used  = r_fallback;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_ok        <= 1'b0;
            r_fallback  <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_ok        <= n_ok;
            r_fallback  <= n_fallback;
            r_idx       <= n_idx;
        end
        r_freq     <= n_freq;
        r_duty     <= n_duty;
        r_min_err  <= n_min_err;
        r_best_per <= n_best_per;
        r_best_pre <= n_best_pre;
        r_per      <= n_per;
        r_q0       <= n_q0;
        r_fb_div   <= n_fb_div;
        r_prod     <= n_prod;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PRS_ASSERT_NOW(a_fail_all_zero, o_out_valid && !o_out_data.setting_ok,
        o_out_data.prescale_value == '0 && o_out_data.reload_value == '0 &&
        o_out_data.compare_value == '0 && !o_out_data.fallback_used)
    `PRS_ASSERT_NOW(a_cmp_within_reload, o_out_valid,
        o_out_data.compare_value <= o_out_data.reload_value)
    `PRS_ASSERT_NOW(a_div_no_restart, div_req.start, !div_stat.busy)
    `PRS_ASSERT_NEXT(a_kept_per_range, r_state == S_REAL_WAIT && div_stat.done && better,
        r_best_per >= 17'(MIN_KEEP_PER) && r_best_per <= 17'(MAX_KEEP_PER))

endmodule

>>> verif/pwm_prescaler_reload_search_tb.sv
`timescale 1ns / 1ps
module pwm_prescaler_reload_search_tb;
    import pwmprs_pkg::*;

    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS = 56;
    localparam int unsigned N_CASES     = 19;
    localparam int unsigned N_PHASES    = 9;

    localparam logic [PADDR_W-1:0] ADDR_TIMER_CLOCK = PADDR_W'({REG_TIMER_CLOCK, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_SPARE       = PADDR_W'(4);

    typedef struct packed {
        logic [31:0] clk_hz;
        logic [31:0] freq;
        logic [16:0] duty;
        logic        fixed_want;
        t_out_item   want;
    } t_tone_case;

    // fixed_want rows carry the all-zero rejected setting
    localparam t_tone_case TONE_CASES [N_CASES] = '{
        '{32'd170000000, 32'd0,        17'd32768,  1'b1, '0},  // zero frequency
        '{32'd170000000, 32'd1,        17'd65536,  1'b0, '0},
        '{32'd170000000, 32'hFFFFFFFF, 17'd65536,  1'b1, '0},  // fallback period count zero
        '{32'd170000000, 32'd1000,     17'd0,      1'b0, '0},
        '{32'd170000000, 32'd1000,     17'd32768,  1'b0, '0},
        '{32'd170000000, 32'd1000,     17'd131071, 1'b0, '0},  // duty above fully on
        '{32'd170000000, 32'd440,      17'd65535,  1'b0, '0},
        '{32'd170000000, 32'd850000,   17'd65536,  1'b0, '0},  // period count at lower bound
        '{32'd170000000, 32'd850001,   17'd1,      1'b0, '0},  // nothing kept, fallback
        '{32'd170000000, 32'd2834,     17'd40000,  1'b0, '0},
        '{32'd170000000, 32'd2833,     17'd40000,  1'b0, '0},  // just over upper bound
        '{32'd170000000, 32'd85000000, 17'd65536,  1'b0, '0},
        '{32'd0,         32'd1000,     17'd32768,  1'b1, '0},  // zero clock
        '{32'd0,         32'd0,        17'd0,      1'b1, '0},
        '{32'hFFFFFFFF,  32'd1,        17'd65536,  1'b1, '0},  // fallback divider too big
        '{32'hFFFFFFFF,  32'd2,        17'd21845,  1'b0, '0},
        '{32'hFFFFFFFF,  32'hFFFFFFFF, 17'd65536,  1'b0, '0},
        '{32'd1,         32'd1,        17'd65536,  1'b0, '0},
        '{32'd1,         32'd2,        17'd65536,  1'b1, '0}   // fallback period count zero
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [31:0] timer_clk_hz;
    t_out_item   pending_settings [$];
    bit          idle_on;
    int unsigned n_errors;
    int unsigned n_tones;
    int unsigned n_results;
    int unsigned n_fallback;
    int unsigned n_rejected;
    int unsigned n_clocks;
    int unsigned quiet_cycles;

    pwm_prescaler_reload_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item calc_timer_setting(logic [31:0] clk_hz, t_in_item req);
        logic [63:0] clk;
        logic [63:0] freq;
        logic [63:0] duty;
        logic [63:0] div;
        logic [63:0] per;
        logic [63:0] achieved;
        logic [63:0] err;
        logic [63:0] best_div;
        logic [63:0] best_per;
        logic [63:0] least_err;
        logic [63:0] cmp;
        logic        found;
        logic        hit;
        logic        fb;
        t_out_item   res;
        res       = '0;
        clk       = 64'(clk_hz);
        freq      = 64'(req.tone_freq_hz);
        duty      = 64'(req.duty_q16);
        found     = 1'b0;
        hit       = 1'b0;
        fb        = 1'b0;
        best_div  = '0;
        best_per  = '0;
        least_err = '0;
        if (freq == 0 || clk == 0) begin
            return res;
        end
        for (int i = 0; i < int'(PRESCALE_TRIES_DEF) && i < 16; i++) begin
            if (!hit) begin
                div = 64'd1 << i;
                per = clk / (div * freq);
                if (per >= 64'(MIN_KEEP_PER) && per <= 64'(MAX_KEEP_PER)) begin
                    achieved = clk / (div * per);
                    err = (achieved > freq) ? achieved - freq : freq - achieved;
                    if (!found || err < least_err) begin
                        found     = 1'b1;
                        least_err = err;
                        best_div  = div;
                        best_per  = per;
                        hit       = (err == 0);
                    end
                end
            end
        end
        if (!found) begin
            div = clk / (freq * 64'(MAX_KEEP_PER)) + 64'd1;
            if (div > 64'(MAX_DIVIDER)) begin
                return res;
            end
            per = clk / (div * freq);
            if (per == 0 || per > 64'(MAX_PERIODS)) begin
                return res;
            end
            best_div = div;
            best_per = per;
            fb       = 1'b1;
        end
        if (duty > 64'(DUTY_ONE)) begin
            duty = 64'(DUTY_ONE);
        end
        cmp = (duty * best_per) >> 16;
        if (cmp > best_per - 64'd1) begin
            cmp = best_per - 64'd1;
        end
        res.setting_ok     = 1'b1;
        res.prescale_value = 16'(best_div - 64'd1);
        res.reload_value   = 16'(best_per - 64'd1);
        res.compare_value  = 16'(cmp);
        res.fallback_used  = fb;
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_timer_clock();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_TIMER_CLOCK, '0, rd);
        if (rd !== timer_clk_hz) begin
            flag_mismatch("timer clock read-back", rd, timer_clk_hz);
        end
    endtask

    task automatic set_timer_clock(logic [31:0] hz);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_TIMER_CLOCK, hz, rd);
        timer_clk_hz = hz;
        n_clocks++;
        check_timer_clock();
    endtask

    // block is idle once every pending setting has come out
    task automatic wait_drained();
        while (pending_settings.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_tone(t_in_item req, bit fixed_want, t_out_item want);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_settings.push_back(fixed_want ? want : calc_timer_setting(timer_clk_hz, req));
        n_tones++;
    endtask

    function automatic logic [31:0] pick_tone(logic [31:0] clk_hz);
        logic [63:0] f;
        case ($urandom_range(0, 9))
            0, 1: f = 64'($urandom);
            2, 3, 4: f = 64'($urandom_range(1, 20000));
            5, 6: f = 64'($urandom_range(1, 2000000));
            7, 8: begin
                // aim at an exact period count for some divider
                f = 64'(clk_hz) / (64'($urandom_range(200, 60000)) << $urandom_range(0, 15));
                if (f == 0) begin
                    f = 64'd1;
                end
            end
            default: f = 64'($urandom_range(0, 10));
        endcase
        return f[31:0];
    endfunction

    function automatic logic [16:0] pick_duty();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DUTY_ONE;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // output side: stall in bursts
    initial begin
        int unsigned burst;
        burst = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) begin
                i_out_stall <= 1'b0;
                burst = 0;
            end else if (burst != 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 4) == 0) begin
                    burst = $urandom_range(1, 9);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_settings.size() == 0) begin
                flag_mismatch("result with nothing pending", 32'(o_out_data), '0);
            end else begin
                want = pending_settings.pop_front();
                n_results++;
                if (want.fallback_used) n_fallback++;
                if (!want.setting_ok) n_rejected++;
                if (o_out_data.setting_ok !== want.setting_ok)
                    flag_mismatch("setting_ok", 32'(o_out_data.setting_ok),
                                  32'(want.setting_ok));
                if (o_out_data.prescale_value !== want.prescale_value)
                    flag_mismatch("prescale_value", 32'(o_out_data.prescale_value),
                                  32'(want.prescale_value));
                if (o_out_data.reload_value !== want.reload_value)
                    flag_mismatch("reload_value", 32'(o_out_data.reload_value),
                                  32'(want.reload_value));
                if (o_out_data.compare_value !== want.compare_value)
                    flag_mismatch("compare_value", 32'(o_out_data.compare_value),
                                  32'(want.compare_value));
                if (o_out_data.fallback_used !== want.fallback_used)
                    flag_mismatch("fallback_used", 32'(o_out_data.fallback_used),
                                  32'(want.fallback_used));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] phase_clk [N_PHASES];
        logic [31:0] rd;
        t_in_item    req;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_on      = 1'b1;
        n_errors     = 0;
        n_tones      = 0;
        n_results    = 0;
        n_fallback   = 0;
        n_rejected   = 0;
        n_clocks     = 0;
        quiet_cycles = 0;
        timer_clk_hz = TIMER_CLOCK_RST;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_timer_clock();

        for (int k = 0; k < int'(N_CASES); k++) begin
            if (TONE_CASES[k].clk_hz != timer_clk_hz) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait_drained();
                set_timer_clock(TONE_CASES[k].clk_hz);
            end
            req.tone_freq_hz = TONE_CASES[k].freq;
            req.duty_q16     = TONE_CASES[k].duty;
            send_tone(req, TONE_CASES[k].fixed_want, TONE_CASES[k].want);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        // a write outside the register map leaves the clock alone
        apb_access(1'b1, ADDR_SPARE, 32'h1234_5678, rd);
        check_timer_clock();

        phase_clk[0] = TIMER_CLOCK_RST;
        phase_clk[1] = 32'hFFFF_FFFF;
        phase_clk[2] = 32'd1;
        phase_clk[3] = 32'd84000000;
        phase_clk[4] = 32'd0;
        phase_clk[5] = $urandom;
        phase_clk[6] = 32'd16000000;
        phase_clk[7] = $urandom_range(1000, 1000000);
        phase_clk[8] = 32'd72000000;

        for (int p = 0; p < int'(N_PHASES); p++) begin
            idle_on = (p != int'(N_PHASES) - 1);
            set_timer_clock(phase_clk[p]);
            for (int n = 0; n < int'(PHASE_ITEMS); n++) begin
                req.tone_freq_hz = pick_tone(timer_clk_hz);
                req.duty_q16     = pick_duty();
                send_tone(req, 1'b0, '0);
            end
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        $display("tone requests: %0d over %0d timer clock settings, incl. zero and full scale",
                 n_tones, n_clocks);
        $display("settings checked: %0d, fallback %0d, rejected %0d",
                 n_results, n_fallback, n_rejected);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> pwm_prescaler_reload_search.f
+incdir+rtl/core
rtl/core/pwmprs_pkg.sv
rtl/core/pwmprs_div.sv
rtl/core/pwm_prescaler_reload_search.sv
verif/pwm_prescaler_reload_search_tb.sv
